FILE: rtl/core/mmeu_pkg.sv
// Package for the mini MIPS execute unit: data widths, opcode codes,
// the decoded instruction record and the queue sizing.
// No dependencies.
`default_nettype none
package mmeu_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int DATA_DEPTH  = 256;
    localparam int MEM_AW      = $clog2(DATA_DEPTH);
    localparam int PC_W        = 9;
    localparam int IMM_W       = 6;
    localparam int ADDR_W      = 7;
    localparam int REG_AW      = 3;
    localparam int NUM_REGS    = 1 << REG_AW;
    localparam int IMM_SLOTS   = 1 << IMM_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] OPC_RTYPE = 4'd0;
    localparam logic [3:0] OPC_J     = 4'd2;
    localparam logic [3:0] OPC_ADDI  = 4'd4;
    localparam logic [3:0] OPC_BEQ   = 4'd8;
    localparam logic [3:0] OPC_LW    = 4'd11;
    localparam logic [3:0] OPC_SW    = 4'd15;

    localparam logic [2:0] FUNCT_ADD = 3'd0;
    localparam logic [2:0] FUNCT_SUB = 3'd2;

    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef enum logic [2:0] {
        K_NOP,
        K_ADD,
        K_SUB,
        K_ADDI,
        K_LW,
        K_SW,
        K_BEQ,
        K_JMP
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [REG_AW-1:0] rs;
        logic [REG_AW-1:0] rt;
        logic [REG_AW-1:0] wr_idx;
        logic [IMM_W-1:0]  imm;
        logic [ADDR_W-1:0] addr;
    } t_op;

endpackage
`default_nettype wire

FILE: rtl/core/mmeu_front.sv
// Front end: takes instruction words and classifies them into decoded
// records for the queue. Depends on mmeu_pkg.
`default_nettype none
module mmeu_front
    import mmeu_pkg::*;
(
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_instruction_word,
    output logic             o_push_valid,
    input  wire logic        i_push_ready,
    output t_op              o_push_op
);

    logic [3:0] opcode;
    logic [2:0] funct;

    assign opcode       = i_instruction_word[15:12];
    assign funct        = i_instruction_word[2:0];
    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid;

    always_comb begin
        o_push_op.rs     = i_instruction_word[11:9];
        o_push_op.rt     = i_instruction_word[8:6];
        o_push_op.imm    = i_instruction_word[5:0];
        o_push_op.addr   = i_instruction_word[6:0];
        o_push_op.wr_idx = i_instruction_word[8:6];
        o_push_op.kind   = K_NOP;
        case (opcode)
            OPC_RTYPE: begin
                // R type writes rd; and/or and other functs stay no-ops
                o_push_op.wr_idx = i_instruction_word[5:3];
                if (funct == FUNCT_ADD) begin
                    o_push_op.kind = K_ADD;
                end else if (funct == FUNCT_SUB) begin
                    o_push_op.kind = K_SUB;
                end
            end
            OPC_ADDI: o_push_op.kind = K_ADDI;
            OPC_LW:   o_push_op.kind = K_LW;
            OPC_SW:   o_push_op.kind = K_SW;
            OPC_BEQ:  o_push_op.kind = K_BEQ;
            OPC_J:    o_push_op.kind = K_JMP;
            default:  o_push_op.kind = K_NOP;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/mmeu_queue.sv
// Short queue of decoded records between front and back end.
// Depends on mmeu_pkg.
`default_nettype none
module mmeu_queue
    import mmeu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_op  i_push_op,
    output logic      o_pop_valid,
    input  wire logic i_pop_ready,
    output t_op       o_pop_op
);

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push, pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_op     = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_op;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/mmeu_back.sv
// Back end: register file, data memory, program counter and result register.
// Reads operands at issue, executes with one-deep forwarding at commit.
// Depends on mmeu_pkg.
`default_nettype none
module mmeu_back
    import mmeu_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [PC_W-1:0]      i_cfg_program_length,
    input  wire logic                 i_pop_valid,
    output logic                      o_pop_ready,
    input  wire t_op                  i_pop_op,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [PC_W-1:0]           o_next_pc,
    output logic                      o_program_done,
    output logic                      o_reg_write,
    output logic [REG_AW-1:0]         o_reg_index,
    output logic signed [31:0]        o_reg_value,
    output logic                      o_mem_write,
    output logic [IMM_W-1:0]          o_mem_address,
    output logic signed [31:0]        o_mem_value
);

    // storage
    t_data             r_rf [NUM_REGS];
    logic              r_rf_vld [NUM_REGS];
    t_data             r_dmem [DATA_DEPTH];
    logic              r_dmem_vld [IMM_SLOTS];
    logic [PC_W-1:0]   r_pc;
    logic [PC_W-1:0]   r_prog_len;

    // execute stage
    logic              r_x_valid;
    t_op               r_x_op;
    t_data             r_rs_data, r_rt_data, r_mem_data;
    logic              r_rs_vld, r_rt_vld, r_mem_vld;

    // last committed writes
    logic              r_fwd_r_valid;
    logic [REG_AW-1:0] r_fwd_r_idx;
    t_data             r_fwd_r_val;
    logic              r_fwd_m_valid;
    logic [IMM_W-1:0]  r_fwd_m_addr;
    t_data             r_fwd_m_val;

    // result register
    logic              r_o_valid;

    logic              x_adv, pop;
    t_data             op_a, op_b, op_m, rval;
    logic              rw, mw;
    logic [PC_W-1:0]   adv, n_pc;

    assign x_adv       = r_x_valid && (!r_o_valid || i_out_ready);
    assign o_pop_ready = !r_x_valid || x_adv;
    assign pop         = i_pop_valid && o_pop_ready;
    assign o_out_valid = r_o_valid;

    always_comb begin
        op_a = r_rs_vld ? r_rs_data : '0;
        op_b = r_rt_vld ? r_rt_data : '0;
        op_m = r_mem_vld ? r_mem_data : '0;
        if (r_fwd_r_valid && r_fwd_r_idx == r_x_op.rs) begin
            op_a = r_fwd_r_val;
        end
        if (r_fwd_r_valid && r_fwd_r_idx == r_x_op.rt) begin
            op_b = r_fwd_r_val;
        end
        if (r_fwd_m_valid && r_fwd_m_addr == r_x_op.imm) begin
            op_m = r_fwd_m_val;
        end

        rw   = 1'b0;
        mw   = 1'b0;
        rval = '0;
        adv  = PC_W'(1);
        case (r_x_op.kind)
            K_ADD: begin
                rw   = 1'b1;
                rval = op_a + op_b;
            end
            K_SUB: begin
                rw   = 1'b1;
                rval = op_a - op_b;
            end
            K_ADDI: begin
                rw   = 1'b1;
                rval = op_b + DATA_WIDTH'(r_x_op.imm);
            end
            K_LW: begin
                rw   = 1'b1;
                rval = op_m;
            end
            K_SW: mw = 1'b1;
            K_BEQ: begin
                if (op_a == op_b) begin
                    adv = PC_W'(r_x_op.imm) + PC_W'(1);
                end
            end
            K_JMP:   adv = PC_W'(r_x_op.addr) + PC_W'(1);
            default: adv = PC_W'(1);
        endcase
        n_pc = r_pc + adv;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc          <= '0;
            r_prog_len    <= '0;
            r_x_valid     <= 1'b0;
            r_o_valid     <= 1'b0;
            r_fwd_r_valid <= 1'b0;
            r_fwd_m_valid <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_rf_vld[i] <= 1'b0;
            end
            for (int i = 0; i < IMM_SLOTS; i++) begin
                r_dmem_vld[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_prog_len <= i_cfg_program_length;
            end
            if (pop) begin
                r_x_valid <= 1'b1;
            end else if (x_adv) begin
                r_x_valid <= 1'b0;
            end
            if (x_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (x_adv) begin
                r_pc <= n_pc;
                if (rw) begin
                    r_fwd_r_valid              <= 1'b1;
                    r_rf_vld[r_x_op.wr_idx]    <= 1'b1;
                end
                if (mw) begin
                    r_fwd_m_valid              <= 1'b1;
                    r_dmem_vld[r_x_op.imm]     <= 1'b1;
                end
            end
        end
    end

    // arrays, operand reads and payload registers
    always_ff @(posedge i_clk) begin
        if (x_adv && rw) begin
            r_rf[r_x_op.wr_idx] <= rval;
            r_fwd_r_idx         <= r_x_op.wr_idx;
            r_fwd_r_val         <= rval;
        end
        if (x_adv && mw) begin
            r_dmem[MEM_AW'(r_x_op.imm)] <= op_b;
            r_fwd_m_addr                <= r_x_op.imm;
            r_fwd_m_val                 <= op_b;
        end
        if (pop) begin
            r_x_op     <= i_pop_op;
            r_rs_data  <= r_rf[i_pop_op.rs];
            r_rs_vld   <= r_rf_vld[i_pop_op.rs];
            r_rt_data  <= r_rf[i_pop_op.rt];
            r_rt_vld   <= r_rf_vld[i_pop_op.rt];
            r_mem_data <= r_dmem[MEM_AW'(i_pop_op.imm)];
            r_mem_vld  <= r_dmem_vld[i_pop_op.imm];
        end
        if (x_adv) begin
            o_next_pc      <= n_pc;
            o_program_done <= (n_pc >= r_prog_len);
            o_reg_write    <= rw;
            o_reg_index    <= rw ? r_x_op.wr_idx : '0;
            o_reg_value    <= rw ? 32'(signed'(rval)) : '0;
            o_mem_write    <= mw;
            o_mem_address  <= mw ? r_x_op.imm : '0;
            o_mem_value    <= mw ? 32'(signed'(op_b)) : '0;
        end
    end

    a_pc_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> o_next_pc == r_pc)
        else $error("result counter differs from architectural counter");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(o_reg_write && o_mem_write))
        else $error("register and memory write in one result");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_reg_write) |-> (o_reg_index == '0 && o_reg_value == '0))
        else $error("register fields not cleared without a write");

    a_fwd_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (x_adv && rw) |=> (r_fwd_r_valid && r_fwd_r_idx == $past(r_x_op.wr_idx)))
        else $error("forward register missed a committed write");

endmodule
`default_nettype wire

FILE: rtl/core/mini_mips_execute_unit.sv
// Top level of the mini MIPS execute unit: front decoder, decoded-record
// queue and back end. Depends on mmeu_pkg, mmeu_front, mmeu_queue, mmeu_back.
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   i_instruction_word[15:0]
//  out       output     o_out_valid / i_out_ready o_next_pc .. o_mem_value
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_program_length[8:0]
//
// One instruction per cycle sustained while the result side is ready. An
// accepted request goes through a queue slot and operand read into execute,
// then into the result register. The register file and data memory
// read ports sit in the issue step; the cycle after, execute forwards the
// last committed write. Synchronous active-low reset clears counter, the
// register file and the data memory (through valid bits). A stalled result
// holds the execute stage; the queue absorbs the front until it fills.
`default_nettype none
module mini_mips_execute_unit
    import mmeu_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [PC_W-1:0]      i_cfg_program_length,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [15:0]          i_instruction_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [PC_W-1:0]           o_next_pc,
    output logic                      o_program_done,
    output logic                      o_reg_write,
    output logic [REG_AW-1:0]         o_reg_index,
    output logic signed [31:0]        o_reg_value,
    output logic                      o_mem_write,
    output logic [IMM_W-1:0]          o_mem_address,
    output logic signed [31:0]        o_mem_value
);

    logic push_valid, push_ready, pop_valid, pop_ready;
    t_op  push_op, pop_op;

    // configuration taken at any time; write it only while idle (unenforced)
    assign o_cfg_ready = 1'b1;

    // classify the incoming word
    mmeu_front u_front (
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_instruction_word (i_instruction_word),
        .o_push_valid       (push_valid),
        .i_push_ready       (push_ready),
        .o_push_op          (push_op)
    );

    // decouple front and back
    mmeu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_op    (push_op),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_op     (pop_op)
    );

    // execute and report
    mmeu_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_program_length (i_cfg_program_length),
        .i_pop_valid          (pop_valid),
        .o_pop_ready          (pop_ready),
        .i_pop_op             (pop_op),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_next_pc            (o_next_pc),
        .o_program_done       (o_program_done),
        .o_reg_write          (o_reg_write),
        .o_reg_index          (o_reg_index),
        .o_reg_value          (o_reg_value),
        .o_mem_write          (o_mem_write),
        .o_mem_address        (o_mem_address),
        .o_mem_value          (o_mem_value)
    );

endmodule
`default_nettype wire

FILE: tb/sv/mini_mips_execute_unit_tb.sv
// Self-checking testbench for mini_mips_execute_unit: drives instruction words and
// program_length writes, predicts every result in its own execution model and checks it.
// Depends on mmeu_pkg and the RTL of the execute unit.
`timescale 1ns / 100ps
module mini_mips_execute_unit_tb;
    import mmeu_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    localparam int NUM_DIRECTED = 25;

    // One result as the block reports it.
    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              done;
        logic              reg_write;
        logic [REG_AW-1:0] reg_index;
        logic [31:0]       reg_value;
        logic              mem_write;
        logic [IMM_W-1:0]  mem_address;
        logic [31:0]       mem_value;
    } exec_result_t;

    // One row of the directed table: the word, and a hand-written result where
    // it is obvious (otherwise the execution model supplies it).
    typedef struct packed {
        logic [15:0]  word;
        logic         typed;
        exec_result_t res;
    } stim_row_t;

    typedef struct packed {
        logic         typed;
        exec_result_t res;
    } typed_tag_t;

    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // add r0 = r0 + r0 straight out of reset
        '{16'h0000, 1'b1, '{9'd1, 1'b0, 1'b1, 3'd0, 32'd0, 1'b0, 6'd0, 32'd0}},
        // addi r1 += 63, largest immediate
        '{16'h407F, 1'b1, '{9'd2, 1'b0, 1'b1, 3'd1, 32'd63, 1'b0, 6'd0, 32'd0}},
        // lw r2 = mem[0], memory cleared by reset
        '{16'hB080, 1'b1, '{9'd3, 1'b0, 1'b1, 3'd2, 32'd0, 1'b0, 6'd0, 32'd0}},
        // addi r0 += 5: register zero is an ordinary register
        '{16'h4005, 1'b1, '{9'd4, 1'b0, 1'b1, 3'd0, 32'd5, 1'b0, 6'd0, 32'd0}},
        '{16'h045A, 1'b0, '0},   // sub r3 = r2 - r1, wraps below zero
        '{16'hF0FF, 1'b0, '0},   // sw mem[63] = r3, top address
        '{16'hB13F, 1'b0, '0},   // lw r4 = mem[63], read back
        '{16'h803F, 1'b0, '0},   // beq r0, r0 taken, largest offset
        '{16'h8205, 1'b0, '0},   // beq r1, r0 not taken
        '{16'h2FFF, 1'b0, '0},   // j 127, upper bits set and ignored
        '{16'h2000, 1'b0, '0},   // j 0
        '{16'h207F, 1'b0, '0},   // j 127 again: counter passes program_length
        '{16'h0FFC, 1'b0, '0},   // and: no-op
        '{16'h0FFD, 1'b0, '0},   // or: no-op
        '{16'h0FFF, 1'b0, '0},   // unknown funct
        '{16'hFFFF, 1'b0, '0},   // all ones: sw mem[63] = r7
        '{16'h1FFF, 1'b0, '0},   // unknown opcodes from here on
        '{16'h3000, 1'b0, '0},
        '{16'h5ABC, 1'b0, '0},
        '{16'h6FFF, 1'b0, '0},
        '{16'h9FFF, 1'b0, '0},
        '{16'hAAAA, 1'b0, '0},
        '{16'hC000, 1'b0, '0},
        '{16'hD555, 1'b0, '0},
        '{16'hE000, 1'b0, '0}
    };

    // Drive every input to a known value from time zero.
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [PC_W-1:0]   i_cfg_program_length = '0;
    logic              i_in_valid = 1'b0;
    logic [15:0]       i_instruction_word = '0;
    logic              i_out_ready = 1'b0;
    wire               o_cfg_ready;
    wire               o_in_ready;
    wire               o_out_valid;
    wire [PC_W-1:0]    o_next_pc;
    wire               o_program_done;
    wire               o_reg_write;
    wire [REG_AW-1:0]  o_reg_index;
    wire signed [31:0] o_reg_value;
    wire               o_mem_write;
    wire [IMM_W-1:0]   o_mem_address;
    wire signed [31:0] o_mem_value;

    mini_mips_execute_unit dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_program_length (i_cfg_program_length),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_instruction_word   (i_instruction_word),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_next_pc            (o_next_pc),
        .o_program_done       (o_program_done),
        .o_reg_write          (o_reg_write),
        .o_reg_index          (o_reg_index),
        .o_reg_value          (o_reg_value),
        .o_mem_write          (o_mem_write),
        .o_mem_address        (o_mem_address),
        .o_mem_value          (o_mem_value)
    );

    // Execution model state: counter, registers, data memory, program length.
    logic [PC_W-1:0]   pc_model = '0;
    t_data             regs_model [NUM_REGS];
    t_data             dmem_model [IMM_SLOTS];
    logic [PC_W-1:0]   prog_len_model = '0;

    exec_result_t      pending_results [$];
    typed_tag_t        typed_tags [$];
    logic              in_taken = 1'b0;
    logic              cfg_taken = 1'b0;
    int                stall_cycles = 0;
    int                fail_count = 0;
    int                items_accepted = 0;
    int                results_checked = 0;
    int                sender_idle_pct = 0;
    int                recv_idle_pct = 0;

    initial begin
        foreach (regs_model[k]) regs_model[k] = '0;
        foreach (dmem_model[k]) dmem_model[k] = '0;
    end

    initial forever #2 i_clk = ~i_clk;

    // Execute one instruction on the model state and return what the block
    // must report for it.
    function automatic exec_result_t execute_instr(input logic [15:0] word);
        logic [3:0]      opc;
        logic [2:0]      rs, rt, rd, fn;
        logic [5:0]      imm;
        logic [6:0]      addr;
        logic [PC_W-1:0] advance;
        exec_result_t    r;
        opc  = word[15:12];
        rs   = word[11:9];
        rt   = word[8:6];
        rd   = word[5:3];
        fn   = word[2:0];
        imm  = word[5:0];
        addr = word[6:0];
        r = '0;
        advance = 9'd1;
        case (opc)
            OPC_RTYPE: begin
                if (fn == FUNCT_ADD || fn == FUNCT_SUB) begin
                    r.reg_write = 1'b1;
                    r.reg_index = rd;
                    r.reg_value = (fn == FUNCT_ADD) ? regs_model[rs] + regs_model[rt]
                                                    : regs_model[rs] - regs_model[rt];
                end
            end
            OPC_ADDI: begin
                r.reg_write = 1'b1;
                r.reg_index = rt;
                r.reg_value = regs_model[rt] + {26'd0, imm};
            end
            OPC_LW: begin
                r.reg_write = 1'b1;
                r.reg_index = rt;
                r.reg_value = dmem_model[imm];
            end
            OPC_SW: begin
                r.mem_write   = 1'b1;
                r.mem_address = imm;
                r.mem_value   = regs_model[rt];
                dmem_model[imm] = regs_model[rt];
            end
            OPC_BEQ: begin
                if (regs_model[rs] == regs_model[rt])
                    advance = {3'd0, imm} + 9'd1;
            end
            OPC_J: begin
                advance = {2'd0, addr} + 9'd1;
            end
            default: ;
        endcase
        if (r.reg_write)
            regs_model[r.reg_index] = r.reg_value;
        // The counter wraps modulo 512 through its width.
        pc_model  = pc_model + advance;
        r.next_pc = pc_model;
        r.done    = (pc_model >= prog_len_model);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp,
                               input logic [31:0] act);
        if (exp !== act) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
            fail_count++;
        end
    endtask

    // Sample every handshake at the rising edge, before the block's outputs move.
    always @(posedge i_clk) begin
        exec_result_t predicted;
        exec_result_t want;
        typed_tag_t   tag;
        in_taken  = i_rst_n && i_in_valid && o_in_ready;
        cfg_taken = i_rst_n && i_cfg_valid && o_cfg_ready;
        if (cfg_taken)
            prog_len_model = i_cfg_program_length;
        if (in_taken) begin
            // Advance the model on every accepted request; a typed row overrides it.
            tag = typed_tags.pop_front();
            predicted = execute_instr(i_instruction_word);
            want = tag.typed ? tag.res : predicted;
            pending_results.push_back(want);
            items_accepted++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with next_pc 0x%0h arrived with nothing expected", o_next_pc);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("next_pc",      want.next_pc,     o_next_pc);
                check_field("program_done", want.done,        o_program_done);
                check_field("reg_write",    want.reg_write,   o_reg_write);
                check_field("reg_index",    want.reg_index,   o_reg_index);
                check_field("reg_value",    want.reg_value,   o_reg_value);
                check_field("mem_write",    want.mem_write,   o_mem_write);
                check_field("mem_address",  want.mem_address, o_mem_address);
                check_field("mem_value",    want.mem_value,   o_mem_value);
                results_checked++;
            end
        end
        if (!i_rst_n || in_taken || cfg_taken || (o_out_valid && i_out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    // Receiver side: drop ready at random, per the current idling percentage.
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Hang detector: end the run if no handshake moves for too long.
    initial begin
        @(negedge i_clk);
        while (stall_cycles < STALL_LIMIT)
            @(negedge i_clk);
        $display("no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_results.size());
        $display("FAILURE");
        $finish;
    end

    // Present one request and hold it until accepted. Valid stays high on
    // return so back-to-back requests need no extra assignment.
    task automatic send_instr(input logic [15:0] word, input logic typed,
                              input exec_result_t res);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        typed_tags.push_back('{typed, res});
        i_in_valid         <= 1'b1;
        i_instruction_word <= word;
        do @(negedge i_clk); while (!in_taken);
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_program_length(input logic [PC_W-1:0] len);
        i_cfg_valid          <= 1'b1;
        i_cfg_program_length <= len;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed operations with random operands, some raw noise.
    function automatic logic [15:0] random_instr();
        logic [2:0] rs, rt, rd, fn;
        logic [6:0] addr;
        int         sel;
        rs   = 3'($urandom_range(7));
        rt   = 3'($urandom_range(7));
        rd   = 3'($urandom_range(7));
        fn   = 3'($urandom_range(7));
        addr = 7'($urandom_range(127));
        sel  = $urandom_range(99);
        if (sel < 8)
            return 16'($urandom_range(16'hFFFF));
        else if (sel < 24)
            return {OPC_RTYPE, rs, rt, rd, FUNCT_ADD};
        else if (sel < 38)
            return {OPC_RTYPE, rs, rt, rd, FUNCT_SUB};
        else if (sel < 42)
            return {OPC_RTYPE, rs, rt, rd, fn};
        else if (sel < 56)
            return {OPC_ADDI, rs, rt, addr[5:0]};
        else if (sel < 68)
            return {OPC_LW, rs, rt, addr[5:0]};
        else if (sel < 80)
            return {OPC_SW, rs, rt, addr[5:0]};
        else if (sel < 86)
            return {OPC_BEQ, rs, rt, addr[5:0]};
        else if (sel < 92)
            return {OPC_BEQ, rs, rs, addr[5:0]};   // equal operands: taken
        else
            return {OPC_J, rs, rt[1:0], addr};
    endfunction

    task automatic run_random_block(input int count);
        int         issued;
        int         burst;
        logic [2:0] r;
        issued = 0;
        while (issued < count) begin
            if ($urandom_range(99) < 3) begin
                // Seed a register, then double it repeatedly so values reach
                // the top bits and wrap.
                r = 3'($urandom_range(7));
                burst = $urandom_range(30, 8);
                send_instr({OPC_ADDI, 3'($urandom_range(7)), r, 6'($urandom_range(63, 1))},
                           1'b0, '0);
                repeat (burst) send_instr({OPC_RTYPE, r, r, r, FUNCT_ADD}, 1'b0, '0);
                issued += burst + 1;
            end else if ($urandom_range(199) == 0) begin
                wait_drained();
            end else begin
                send_instr(random_instr(), 1'b0, '0);
                issued++;
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase 1: sender idles rarely, receiver stalls most cycles.
        sender_idle_pct = 9;
        recv_idle_pct   = 74;
        write_program_length(9'd256);
        for (int k = 0; k < NUM_DIRECTED; k++)
            send_instr(DIRECTED_ROWS[k].word, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].res);
        wait_drained();
        write_program_length(9'd0);
        run_random_block(650);
        wait_drained();

        // Phase 2: roles swapped; program_length at its widest value.
        sender_idle_pct = 74;
        recv_idle_pct   = 9;
        write_program_length(9'd511);
        run_random_block(650);
        wait_drained();

        // Phase 3: full rate on both sides, a mid-range program_length.
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        write_program_length(9'($urandom_range(255, 1)));
        run_random_block(650);
        wait_drained();
        repeat (8) @(negedge i_clk);

        $display("Executed %0d instructions and checked %0d results", items_accepted,
                 results_checked);
        $display("under program_length 256, 0, 511 and a random mid value; %0d mismatches.",
                 fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mmeu_pkg.sv
rtl/core/mmeu_front.sv
rtl/core/mmeu_queue.sv
rtl/core/mmeu_back.sv
rtl/core/mini_mips_execute_unit.sv
tb/sv/mini_mips_execute_unit_tb.sv
